/* sv/bba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, field widths and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int IDX_W    = 10;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int WORD_LSB = 5;

  localparam logic [CFG_W-1:0] NUM_BLOCKS_RST = 11'd1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic    start;
    logic    scan_next;
    logic    free_write;
    logic    alloc_write;
    logic    set_res;
    status_e res_code;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic idx_bad;
    logic word_clean;
    logic cnt_zero;
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [WORD_LSB-1:0] lowest_set_bit(input word_t v);
    logic [WORD_LSB-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_LSB'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/bba_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_if
// Request, response and configuration channels of the block allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] free_idx;
  modport source (output valid, output mode, output free_idx, input ready);
  modport sink (input valid, input mode, input free_idx, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  modport source (output valid, output status, output granted_index, input ready);
  modport sink (input valid, input status, input granted_index, output ready);
endinterface

interface bba_cfg_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/bba_map_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_map_ram
// Bitmap word store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire bba_pkg::word_t       wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output      bba_pkg::word_t       rd_data_o
);
  import bba_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* sv/bba_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap store, word scan, free update, config register and result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_mode_i,
  input  wire logic [bba_pkg::IDX_W-1:0]     req_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bba_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire bba_pkg::dp_cmd_t              cmd_i,
  output      bba_pkg::dp_stat_t             stat_o,
  input  wire logic                          rsp_ready_i,
  output      logic                          rsp_valid_o,
  output      logic [bba_pkg::STATUS_W-1:0]  rsp_status_o,
  output      logic [bba_pkg::IDX_W-1:0]     rsp_grant_o
);
  import bba_pkg::*;

  localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HW    = $clog2(WORDS + 1);
  localparam int CW0   = $clog2(MAX_BLOCKS + 1);
  localparam int NW    = ((CW0 > CFG_W) ? CW0 : CFG_W) + 1;

  logic [CFG_W-1:0]    num_blocks_q, num_blocks_d;
  logic [HW-1:0]       hw_q, hw_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [AW-1:0]       chk_ptr_q, chk_ptr_d;
  status_e             res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_grant_q, res_grant_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [IDX_W-1:0]    rsp_grant_q, rsp_grant_d;

  logic [NW-1:0]       count_ext, base_ext, end_ext, rem_ext, grant_ext;
  logic                word_full;
  word_t               valid_mask, rd_data, scan_word, free_bits, wr_data;
  logic [WORD_LSB-1:0] hit_bit;
  logic [AW-1:0]       rd_addr, wr_addr, req_word;
  logic                rd_en, wr_en;

  assign count_ext = (NW'(num_blocks_q) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS)
                                                           : NW'(num_blocks_q);
  assign base_ext  = NW'(chk_ptr_q) << WORD_LSB;
  assign end_ext   = base_ext + NW'(WORD_W);
  assign rem_ext   = count_ext - base_ext;
  assign word_full = end_ext <= count_ext;
  assign valid_mask = word_full ? '1
                    : ((word_t'(1) << rem_ext[WORD_LSB-1:0]) - word_t'(1));

  assign scan_word = (HW'(chk_ptr_q) < hw_q) ? rd_data : '0;
  assign free_bits = ~scan_word & valid_mask;
  assign hit_bit   = lowest_set_bit(free_bits);
  assign grant_ext = base_ext + NW'(hit_bit);
  assign req_word  = AW'(req_index_i[IDX_W-1:WORD_LSB]);

  always_comb begin
    stat_o            = '0;
    stat_o.req_free   = (req_mode_i == MODE_FREE);
    stat_o.idx_bad    = NW'(req_index_i) >= count_ext;
    stat_o.word_clean = HW'(req_index_i[IDX_W-1:WORD_LSB]) >= hw_q;
    stat_o.cnt_zero   = (count_ext == '0);
    stat_o.hit        = |free_bits;
    stat_o.last       = end_ext >= count_ext;
    stat_o.out_free   = !rsp_valid_q || rsp_ready_i;
  end

  assign rd_en   = cmd_i.start || cmd_i.scan_next;
  assign rd_addr = cmd_i.start ? ((req_mode_i == MODE_FREE) ? req_word : '0)
                               : chk_ptr_q + 1'b1;
  assign wr_en   = cmd_i.free_write || cmd_i.alloc_write;
  assign wr_addr = cmd_i.free_write ? AW'(idx_q[IDX_W-1:WORD_LSB]) : chk_ptr_q;
  assign wr_data = cmd_i.free_write
                 ? (rd_data & ~(word_t'(1) << idx_q[WORD_LSB-1:0]))
                 : (scan_word | (word_t'(1) << hit_bit));

  bba_map_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    num_blocks_d = cfg_we_i ? cfg_data_i : num_blocks_q;
    hw_d         = hw_q;
    if (cmd_i.alloc_write && (HW'(chk_ptr_q) == hw_q)) begin
      hw_d = hw_q + 1'b1;
    end
    idx_d     = cmd_i.start ? req_index_i : idx_q;
    chk_ptr_d = chk_ptr_q;
    if (cmd_i.start) begin
      chk_ptr_d = '0;
    end else if (cmd_i.scan_next) begin
      chk_ptr_d = chk_ptr_q + 1'b1;
    end
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    if (cmd_i.alloc_write) begin
      res_status_d = STATUS_OK;
      res_grant_d  = grant_ext[IDX_W-1:0];
    end else if (cmd_i.set_res) begin
      res_status_d = cmd_i.res_code;
      res_grant_d  = '0;
    end
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_grant_d  = rsp_grant_q;
    if (cmd_i.emit) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = res_status_q;
      rsp_grant_d  = res_grant_q;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= NUM_BLOCKS_RST;
      hw_q         <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      num_blocks_q <= num_blocks_d;
      hw_q         <= hw_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    chk_ptr_q    <= chk_ptr_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    rsp_status_q <= rsp_status_d;
    rsp_grant_q  <= rsp_grant_d;
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_grant_o  = rsp_grant_q;

endmodule
`default_nettype wire

/* sv/bba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: free update, word-by-word allocate scan, result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output      logic               req_ready_o,
  input  wire bba_pkg::dp_stat_t  stat_i,
  output      bba_pkg::dp_cmd_t   cmd_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_FREE_WR = 4'b0010,
    S_SCAN    = 4'b0100,
    S_DONE    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_code = STATUS_OK;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          if (stat_i.req_free) begin
            if (stat_i.idx_bad) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = STATUS_BAD_INDEX;
              state_d        = S_DONE;
            end else if (stat_i.word_clean) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = STATUS_OK;
              state_d        = S_DONE;
            end else begin
              state_d = S_FREE_WR;
            end
          end else if (stat_i.cnt_zero) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STATUS_NO_SPACE;
            state_d        = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FREE_WR: begin
        cmd_o.free_write = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_code   = STATUS_OK;
        state_d          = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.alloc_write = 1'b1;
          state_d           = S_DONE;
        end else if (stat_i.last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STATUS_NO_SPACE;
          state_d        = S_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* sv/bitmap_block_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in 32-bit words.
// ----------------------------------------------------------------------------
// free request: read, bit-clear write, response; no write if its word was never written
// allocate: scans one bitmap word per cycle through the store's read port,
//   stopping at the first word with a free block or at the last word within the count
// one request at a time; the next is taken once the result sits in the output register
// reset frees every block at once through a written-word high-water mark, no clearing pass;
//   the block count register resets to 1024
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bba_req_if.sink    req_i,
  bba_rsp_if.source  rsp_o,
  bba_cfg_if.sink    cfg_i
);
  import bba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mode_i   (req_i.mode),
    .req_index_i  (req_i.free_idx),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_grant_o  (rsp_o.granted_index)
  );

endmodule
`default_nettype wire
